// ===== src/mmc_sysex_command_encoder_core_macros.svh =====
// Assertion macros for the MMC SysEx command encoder.
// Expects signals clk and rst in the scope of each use.
`ifndef MMC_SYSEX_COMMAND_ENCODER_CORE_MACROS_SVH
`define MMC_SYSEX_COMMAND_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/msce_pkg.sv =====
// Shared types, constants and byte encoder of the MMC SysEx command encoder.
// No dependencies.
package msce_pkg;

  localparam int QDEPTH = 2;

  localparam logic [7:0] SYX_START  = 8'hF0;
  localparam logic [7:0] SYX_END    = 8'hF7;
  localparam logic [7:0] MMC_RT     = 8'h7F;
  localparam logic [7:0] MMC_SUBID  = 8'h06;
  localparam logic [7:0] LOC_COUNT  = 8'h06;
  localparam logic [7:0] LOC_TARGET = 8'h01;
  localparam logic [1:0] RATE_25    = 2'd1;

  localparam logic [7:0] CMD_STOP   = 8'h01;
  localparam logic [7:0] CMD_PLAY   = 8'h02;
  localparam logic [7:0] CMD_PAUSE  = 8'h09;
  localparam logic [7:0] CMD_LOCATE = 8'h44;

  // Divisors of the position split and their 2^32 reciprocals.
  localparam logic [6:0]  DIV_SF  = 7'd100;
  localparam logic [6:0]  DIV_FR  = 7'd25;
  localparam logic [6:0]  DIV_SC  = 7'd60;
  localparam logic [6:0]  DIV_MN  = 7'd60;
  localparam logic [27:0] RCP_SF  = 28'((64'd1 << 32) / 100);
  localparam logic [27:0] RCP_FR  = 28'((64'd1 << 32) / 25);
  localparam logic [27:0] RCP_SC  = 28'((64'd1 << 32) / 60);
  localparam logic [27:0] RCP_MN  = 28'((64'd1 << 32) / 60);

  localparam logic [1:0] STEP_SF = 2'd0;
  localparam logic [1:0] STEP_FR = 2'd1;
  localparam logic [1:0] STEP_SC = 2'd2;
  localparam logic [1:0] STEP_MN = 2'd3;

  // Byte positions within a message.
  localparam logic [3:0] BI_START  = 4'd0;
  localparam logic [3:0] BI_RT     = 4'd1;
  localparam logic [3:0] BI_DEV    = 4'd2;
  localparam logic [3:0] BI_SUBID  = 4'd3;
  localparam logic [3:0] BI_CMD    = 4'd4;
  localparam logic [3:0] BI_COUNT  = 4'd5;
  localparam logic [3:0] BI_TARGET = 4'd6;
  localparam logic [3:0] BI_HR     = 4'd7;
  localparam logic [3:0] BI_MN     = 4'd8;
  localparam logic [3:0] BI_SC     = 4'd9;
  localparam logic [3:0] BI_FR     = 4'd10;
  localparam logic [3:0] BI_SF     = 4'd11;
  localparam logic [3:0] BI_END    = 4'd12;

  typedef enum logic [1:0] {
    FN_STOP,
    FN_PLAY,
    FN_PAUSE,
    FN_LOCATE
  } func_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_FIX,
    FS_PUSH
  } front_state_t;

  typedef struct packed {
    logic [4:0] hr;
    logic [5:0] mn;
    logic [5:0] sc;
    logic [4:0] fr;
    logic [6:0] sf;
  } timecode_t;

  typedef struct packed {
    func_t     func;
    timecode_t tc;
  } cmd_entry_t;

  function automatic logic [7:0] cmd_code(func_t f);
    logic [7:0] c;
    case (f)
      FN_STOP:  c = CMD_STOP;
      FN_PLAY:  c = CMD_PLAY;
      FN_PAUSE: c = CMD_PAUSE;
      default:  c = CMD_LOCATE;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] step_divisor(logic [1:0] step);
    logic [6:0] d;
    case (step)
      STEP_SF: d = DIV_SF;
      STEP_FR: d = DIV_FR;
      STEP_SC: d = DIV_SC;
      default: d = DIV_MN;
    endcase
    return d;
  endfunction

  function automatic logic [27:0] step_recip(logic [1:0] step);
    logic [27:0] m;
    case (step)
      STEP_SF: m = RCP_SF;
      STEP_FR: m = RCP_FR;
      STEP_SC: m = RCP_SC;
      default: m = RCP_MN;
    endcase
    return m;
  endfunction

  // Returns {last, byte} for position idx of the message for entry e.
  function automatic logic [8:0] encode_byte(logic [3:0] idx, cmd_entry_t e,
                                             logic [6:0] dev);
    logic [8:0] r;
    logic       loc;
    loc = (e.func == FN_LOCATE);
    case (idx)
      BI_START:  r = {1'b0, SYX_START};
      BI_RT:     r = {1'b0, MMC_RT};
      BI_DEV:    r = {1'b0, 1'b0, dev};
      BI_SUBID:  r = {1'b0, MMC_SUBID};
      BI_CMD:    r = {1'b0, cmd_code(e.func)};
      BI_COUNT:  r = loc ? {1'b0, LOC_COUNT} : {1'b1, SYX_END};
      BI_TARGET: r = {1'b0, LOC_TARGET};
      BI_HR:     r = {1'b0, 1'b0, RATE_25, e.tc.hr};
      BI_MN:     r = {1'b0, 2'b00, e.tc.mn};
      BI_SC:     r = {1'b0, 2'b00, e.tc.sc};
      BI_FR:     r = {1'b0, 3'b000, e.tc.fr};
      BI_SF:     r = {1'b0, 1'b0, e.tc.sf};
      default:   r = {1'b1, SYX_END};
    endcase
    return r;
  endfunction

endpackage

// ===== src/mmc_sysex_command_encoder_core.sv =====
// MMC SysEx command encoder: transport command in, SysEx bytes out.
// A short command goes from the front end straight to the queue; a locate first
// passes four divide steps in the front end, each a multiply state and a fix state.
// Throughput: one byte per cycle from the back-end serializer while the output is
// free or popped; a short message has 6 bytes and a locate message 13. Synchronous
// reset empties the queue and the output stage and sets device_id to 127; no clearing pass.
module mmc_sysex_command_encoder_core import msce_pkg::*; #(
  parameter int QUEUE_DEPTH = QDEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // command input
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [29:0] position_subframes,
  // configuration
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,
  // byte output
  output logic [7:0]  out_byte,
  output logic        last_byte,
  output logic        empty,
  input  logic        pop
);

  `include "mmc_sysex_command_encoder_core_macros.svh"

  // Device id register; the user must write it only while the block is idle (the block
  // itself does not enforce this), so the back end reads it live for every message.
  logic [6:0] device_id;

  always_ff @(posedge clk) begin
    if (rst) device_id <= 7'h7F;
    else if (cfg_we) device_id <= cfg_data;
  end

  // Front to queue.
  logic       q_push;
  cmd_entry_t q_wr_data;
  logic       q_full;
  // Queue to back.
  logic       q_pop;
  cmd_entry_t q_rd_data;
  logic       q_empty;

  // Front end: take a command, split a locate position into hr/mn/sc/fr/sf by
  // reciprocal multiply and correct, then hand the item to the queue.
  msce_front u_front (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .func               (func),
    .position_subframes (position_subframes),
    .q_push             (q_push),
    .q_data             (q_wr_data),
    .q_full             (q_full)
  );

  // Decouple the front end from the serializer so each stalls on its own.
  msce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Back end: walk the message bytes into the output register.
  msce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .device_id (device_id),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .empty     (empty),
    .pop       (pop)
  );

  // F7 never occurs inside a message, so it marks the last byte exactly.
  `MSCE_ASSERT_IMP(a_last_is_end, !empty, last_byte == (out_byte == SYX_END), "last mark off F7")
  // The front end never writes into a full queue.
  `MSCE_ASSERT_IMP(a_no_overflow, q_push, !q_full, "push into full queue")
  // A pushed item is visible to the back end in the next cycle.
  `MSCE_ASSERT_NXT(a_push_lands, q_push, !q_empty, "pushed item lost")

endmodule

// ===== src/msce_front.sv =====
// Front end: accepts commands and splits locate positions into time code.
// Depends on msce_pkg.
module msce_front import msce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [29:0] position_subframes,
  output logic        q_push,
  output cmd_entry_t  q_data,
  input  logic        q_full
);

  front_state_t state, state_next;
  logic [1:0]   step;
  logic [29:0]  work;
  logic [57:0]  prod;
  cmd_entry_t   entry;

  logic         accept;
  logic [6:0]   d;
  logic [25:0]  q0;
  logic [30:0]  qd;
  logic [30:0]  r_raw;
  logic         fix;
  logic [30:0]  rem;
  logic [29:0]  quo;

  always_comb begin
    state_next = state;
    full       = 1'b1;
    q_push     = 1'b0;
    case (state)
      FS_IDLE: full = 1'b0;
      FS_PUSH: begin
        q_push = !q_full;
        full   = q_full;
        if (!q_full) state_next = FS_IDLE;
      end
      FS_MUL:  state_next = FS_FIX;
      FS_FIX:  state_next = (step == STEP_MN) ? FS_PUSH : FS_MUL;
      default: state_next = FS_IDLE;
    endcase
    accept = push && !full;
    if (accept) begin
      state_next = (func_t'(func) == FN_LOCATE) ? FS_MUL : FS_PUSH;
    end
  end

  // Reciprocal quotient is at most one short; one compare fixes it.
  always_comb begin
    d     = step_divisor(step);
    q0    = prod[57:32];
    qd    = 31'(q0) * 31'(d);
    r_raw = {1'b0, work} - qd;
    fix   = (r_raw >= 31'(d));
    rem   = fix ? r_raw - 31'(d) : r_raw;
    quo   = 30'(q0) + 30'(fix);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
      step  <= STEP_SF;
    end else begin
      state <= state_next;
      if (accept) step <= STEP_SF;
      else if (state == FS_FIX) step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry.func <= func_t'(func);
      work       <= position_subframes;
    end else if (state == FS_MUL) begin
      prod <= 58'(work) * 58'(step_recip(step));
    end else if (state == FS_FIX) begin
      work <= quo;
      case (step)
        STEP_SF: entry.tc.sf <= rem[6:0];
        STEP_FR: entry.tc.fr <= rem[4:0];
        STEP_SC: entry.tc.sc <= rem[5:0];
        default: begin
          entry.tc.mn <= rem[5:0];
          entry.tc.hr <= quo[4:0];
        end
      endcase
    end
  end

  assign q_data = entry;

endmodule

// ===== src/msce_queue.sv =====
// Small command queue between the front and back ends.
// Depends on msce_pkg.
module msce_queue import msce_pkg::*; #(
  parameter int DEPTH = QDEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  cmd_entry_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output cmd_entry_t rd_data,
  output logic       empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_entry_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (rd_en) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (wr_en && !rd_en) count <= count + CW'(1);
      else if (rd_en && !wr_en) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

endmodule

// ===== src/msce_back.sv =====
// Back end: serializes one queued command into SysEx bytes, one per cycle while the output is free or popped.
// Depends on msce_pkg.
module msce_back import msce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [6:0] device_id,
  input  logic       q_empty,
  input  cmd_entry_t q_data,
  output logic       q_pop,
  output logic [7:0] out_byte,
  output logic       last_byte,
  output logic       empty,
  input  logic       pop
);

  logic       busy;
  logic [3:0] idx;
  cmd_entry_t held;
  logic       out_valid;

  logic       load_ok;
  logic       emit;
  logic [8:0] cur;

  always_comb begin
    load_ok = !out_valid || pop;
    cur     = encode_byte(idx, held, device_id);
    emit    = busy && load_ok;
    // Fetch the next command on the closing byte so messages run back to back.
    q_pop   = !q_empty && (!busy || (emit && cur[8]));
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= BI_START;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= BI_START;
      end else if (emit) begin
        if (cur[8]) busy <= 1'b0;
        else idx <= idx + 4'd1;
      end
      if (emit) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) held <= q_data;
    if (emit) begin
      out_byte  <= cur[7:0];
      last_byte <= cur[8];
    end
  end

endmodule
